// ===== rtl/rational_add_multiply_reduce_defines.svh =====
// assertion macros for the rational add/multiply block
`ifndef RATIONAL_ADD_MULTIPLY_REDUCE_DEFINES_SVH
`define RATIONAL_ADD_MULTIPLY_REDUCE_DEFINES_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define RAMR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ramr: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define RAMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ramr: next-cycle check failed");

`else

`define RAMR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RAMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/ramr_pkg.sv =====
`timescale 1ns / 1ps

package ramr_pkg;

    // operand width default and fixed result widths
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int NUM_OUT_W         = 33;
    localparam int DEN_OUT_W         = 32;

    // operation select codes
    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_MUL = 1'b1;

    // sequencer states of the top level
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_EUC_INIT,
        ST_EUC_CHK,
        ST_EUC_WAIT,
        ST_WAIT_NUM,
        ST_DIV_DEN,
        ST_WAIT_DEN,
        ST_DONE
    } ramr_state_t;

    // divider states
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIX
    } div_state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/ramr_mul.sv =====
`timescale 1ns / 1ps

module ramr_mul #(
    parameter int OPERAND_WIDTH = ramr_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic signed [OPERAND_WIDTH-1:0]  a,
    input  logic signed [OPERAND_WIDTH-1:0]  b,
    output logic signed [2*OPERAND_WIDTH-1:0] p
);

    localparam int PROD_W = 2 * OPERAND_WIDTH;

    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;

    // full-width signed product
    assign p_next = PROD_W'(a) * PROD_W'(b);

    // product register
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== rtl/ramr_div.sv =====
`timescale 1ns / 1ps

module ramr_div #(
    parameter int RAW_W = 33
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [RAW_W-1:0] dividend,
    input  logic signed [RAW_W-1:0] divisor,
    output logic signed [RAW_W-1:0] quo,
    output logic signed [RAW_W-1:0] rem,
    output ramr_pkg::div_stat_t     stat
);

    localparam int CNT_W = $clog2(RAW_W + 1);

    ramr_pkg::div_state_t state_reg;
    ramr_pkg::div_state_t state_next;

    logic [CNT_W-1:0]        cnt_reg;
    logic                    done_reg;
    logic [RAW_W-1:0]        part_reg;
    logic [RAW_W-1:0]        dvd_reg;
    logic [RAW_W-1:0]        dvs_reg;
    logic                    neg_q_reg;
    logic                    neg_r_reg;
    logic signed [RAW_W-1:0] quo_reg;
    logic signed [RAW_W-1:0] rem_reg;

    logic [RAW_W-1:0] abs_dividend;
    logic [RAW_W-1:0] abs_divisor;
    logic [RAW_W:0]   cand;
    logic [RAW_W:0]   diff;
    logic             ge;

    // magnitudes of the operands
    assign abs_dividend = dividend[RAW_W-1] ? (RAW_W'(0) - dividend) : dividend;
    assign abs_divisor  = divisor[RAW_W-1] ? (RAW_W'(0) - divisor) : divisor;

    // one restoring step: shift in next dividend bit, trial subtract
    assign cand = {part_reg, dvd_reg[RAW_W-1]};
    assign diff = cand - {1'b0, dvs_reg};
    assign ge   = ~diff[RAW_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ramr_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = ramr_pkg::DIV_RUN;
                end
            end
            ramr_pkg::DIV_RUN:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ramr_pkg::DIV_FIX;
                end
            end
            ramr_pkg::DIV_FIX:
            begin
                state_next = ramr_pkg::DIV_IDLE;
            end
            default:
            begin
                state_next = ramr_pkg::DIV_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ramr_pkg::DIV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ramr_pkg::DIV_FIX);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ramr_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    part_reg  <= '0;
                    dvd_reg   <= abs_dividend;
                    dvs_reg   <= abs_divisor;
                    neg_q_reg <= dividend[RAW_W-1] ^ divisor[RAW_W-1];
                    neg_r_reg <= dividend[RAW_W-1];
                    cnt_reg   <= CNT_W'(RAW_W);
                end
            end
            ramr_pkg::DIV_RUN:
            begin
                part_reg <= ge ? diff[RAW_W-1:0] : cand[RAW_W-1:0];
                dvd_reg  <= {dvd_reg[RAW_W-2:0], ge};
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            ramr_pkg::DIV_FIX:
            begin
                // apply truncating signs
                quo_reg <= neg_q_reg ? (RAW_W'(0) - dvd_reg) : dvd_reg;
                rem_reg <= neg_r_reg ? (RAW_W'(0) - part_reg) : part_reg;
            end
            default:
            begin
                part_reg <= part_reg;
            end
        endcase
    end

    assign quo       = quo_reg;
    assign rem       = rem_reg;
    assign stat.busy = (state_reg != ramr_pkg::DIV_IDLE);
    assign stat.done = done_reg;

endmodule

// ===== rtl/rational_add_multiply_reduce.sv =====
`timescale 1ns / 1ps

// Adds (mode 0) or multiplies (mode 1) two signed fractions and reduces the
// result by a signed Euclidean divisor, truncating remainders and quotients.
// Input channel: in_valid/in_stall with mode and the four operand fields;
// a transfer happens when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with res_num, res_den, zero_divisor;
// zero_divisor is set (and both parts are zero) when both raw parts are zero.
// One item at a time: in_stall stays high from a transfer until the result
// is loaded into the output register. With R = min(2*OPERAND_WIDTH+1, 64)
// the shared restoring divider works on R-bit raw values and serves every
// Euclid step as well as both final quotients.
// Three products go through one registered multiplier first.
// A new item can be taken while a result waits in the output register; the
// next result then waits until out_stall drops.
// Reset (rst_n low, asynchronous) empties the output and returns to idle.

`include "rational_add_multiply_reduce_defines.svh"

module rational_add_multiply_reduce #(
    parameter int OPERAND_WIDTH = ramr_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  mode,
    input  logic signed [OPERAND_WIDTH-1:0]       lhs_num,
    input  logic signed [OPERAND_WIDTH-1:0]       lhs_den,
    input  logic signed [OPERAND_WIDTH-1:0]       rhs_num,
    input  logic signed [OPERAND_WIDTH-1:0]       rhs_den,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ramr_pkg::NUM_OUT_W-1:0] res_num,
    output logic signed [ramr_pkg::DEN_OUT_W-1:0] res_den,
    output logic                                  zero_divisor
);

    localparam int W      = OPERAND_WIDTH;
    localparam int PROD_W = 2 * W;
    localparam int RAW_W  = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
    localparam int NUM_W  = ramr_pkg::NUM_OUT_W;
    localparam int DEN_W  = ramr_pkg::DEN_OUT_W;

    ramr_pkg::ramr_state_t state_reg;
    ramr_pkg::ramr_state_t state_next;

    // latched operands
    logic                    mode_reg;
    logic signed [W-1:0]     lhs_num_reg;
    logic signed [W-1:0]     lhs_den_reg;
    logic signed [W-1:0]     rhs_num_reg;
    logic signed [W-1:0]     rhs_den_reg;

    // raw fraction, euclid pair and quotients
    logic signed [RAW_W-1:0] num_reg;
    logic signed [RAW_W-1:0] den_reg;
    logic signed [RAW_W-1:0] x_reg;
    logic signed [RAW_W-1:0] y_reg;
    logic signed [RAW_W-1:0] numq_reg;
    logic signed [RAW_W-1:0] denq_reg;
    logic                    err_reg;

    // output register
    logic                    out_valid_reg;
    logic signed [NUM_W-1:0] res_num_reg;
    logic signed [DEN_W-1:0] res_den_reg;
    logic                    zero_divisor_reg;

    // shared units
    logic signed [W-1:0]      mul_a;
    logic signed [W-1:0]      mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [RAW_W-1:0]  prod_raw;
    logic                     div_start;
    logic signed [RAW_W-1:0]  div_a;
    logic signed [RAW_W-1:0]  div_b;
    logic signed [RAW_W-1:0]  div_quo;
    logic signed [RAW_W-1:0]  div_rem;
    ramr_pkg::div_stat_t      div_stat;

    logic in_xfer;
    logic out_free;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign prod_raw = RAW_W'(prod);

    ramr_mul #(
        .OPERAND_WIDTH(W)
    ) u_mul (
        .clk(clk),
        .a  (mul_a),
        .b  (mul_b),
        .p  (prod)
    );

    ramr_div #(
        .RAW_W(RAW_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_a),
        .divisor (div_b),
        .quo     (div_quo),
        .rem     (div_rem),
        .stat    (div_stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ramr_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ramr_pkg::ST_MUL_A;
                end
            end
            ramr_pkg::ST_MUL_A:    state_next = ramr_pkg::ST_MUL_B;
            ramr_pkg::ST_MUL_B:    state_next = ramr_pkg::ST_MUL_C;
            ramr_pkg::ST_MUL_C:    state_next = ramr_pkg::ST_EUC_INIT;
            ramr_pkg::ST_EUC_INIT: state_next = ramr_pkg::ST_EUC_CHK;
            ramr_pkg::ST_EUC_CHK:
            begin
                if (y_reg != '0)
                begin
                    state_next = ramr_pkg::ST_EUC_WAIT;
                end
                else if (x_reg == '0)
                begin
                    state_next = ramr_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ramr_pkg::ST_WAIT_NUM;
                end
            end
            ramr_pkg::ST_EUC_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ramr_pkg::ST_EUC_CHK;
                end
            end
            ramr_pkg::ST_WAIT_NUM:
            begin
                if (div_stat.done)
                begin
                    state_next = ramr_pkg::ST_DIV_DEN;
                end
            end
            ramr_pkg::ST_DIV_DEN:  state_next = ramr_pkg::ST_WAIT_DEN;
            ramr_pkg::ST_WAIT_DEN:
            begin
                if (div_stat.done)
                begin
                    state_next = ramr_pkg::ST_DONE;
                end
            end
            ramr_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ramr_pkg::ST_IDLE;
                end
            end
            default:               state_next = ramr_pkg::ST_IDLE;
        endcase
    end

    // unit operand selection
    always_comb
    begin
        mul_a     = lhs_den_reg;
        mul_b     = rhs_den_reg;
        div_start = 1'b0;
        div_a     = x_reg;
        div_b     = y_reg;
        case (state_reg)
            ramr_pkg::ST_MUL_A:
            begin
                mul_a = lhs_num_reg;
                mul_b = (mode_reg == ramr_pkg::MODE_MUL) ? rhs_num_reg : rhs_den_reg;
            end
            ramr_pkg::ST_MUL_B:
            begin
                mul_a = rhs_num_reg;
                mul_b = lhs_den_reg;
            end
            ramr_pkg::ST_EUC_CHK:
            begin
                // next remainder step, or the numerator once the divisor is known
                if (y_reg != '0)
                begin
                    div_start = 1'b1;
                end
                else if (x_reg != '0)
                begin
                    div_start = 1'b1;
                    div_a     = num_reg;
                    div_b     = x_reg;
                end
            end
            ramr_pkg::ST_DIV_DEN:
            begin
                div_start = 1'b1;
                div_a     = den_reg;
                div_b     = x_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ramr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ramr_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ramr_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    mode_reg    <= mode;
                    lhs_num_reg <= lhs_num;
                    lhs_den_reg <= lhs_den;
                    rhs_num_reg <= rhs_num;
                    rhs_den_reg <= rhs_den;
                end
            end
            ramr_pkg::ST_MUL_B:
            begin
                num_reg <= prod_raw;
            end
            ramr_pkg::ST_MUL_C:
            begin
                // cross sum wraps at the raw width
                if (mode_reg == ramr_pkg::MODE_ADD)
                begin
                    num_reg <= num_reg + prod_raw;
                end
            end
            ramr_pkg::ST_EUC_INIT:
            begin
                den_reg <= prod_raw;
                x_reg   <= num_reg;
                y_reg   <= prod_raw;
            end
            ramr_pkg::ST_EUC_CHK:
            begin
                err_reg <= (y_reg == '0) && (x_reg == '0);
            end
            ramr_pkg::ST_EUC_WAIT:
            begin
                if (div_stat.done)
                begin
                    x_reg <= y_reg;
                    y_reg <= div_rem;
                end
            end
            ramr_pkg::ST_WAIT_NUM:
            begin
                if (div_stat.done)
                begin
                    numq_reg <= div_quo;
                end
            end
            ramr_pkg::ST_WAIT_DEN:
            begin
                if (div_stat.done)
                begin
                    denq_reg <= div_quo;
                end
            end
            ramr_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    res_num_reg      <= err_reg ? '0 : NUM_W'(numq_reg);
                    res_den_reg      <= err_reg ? '0 : DEN_W'(denq_reg);
                    zero_divisor_reg <= err_reg;
                end
            end
            default:
            begin
                err_reg <= err_reg;
            end
        endcase
    end

    assign in_stall     = (state_reg != ramr_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign res_num      = res_num_reg;
    assign res_den      = res_den_reg;
    assign zero_divisor = zero_divisor_reg;

    // checks
    `RAMR_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, in_stall)
    `RAMR_ASSERT_IMPL(a_div_free_at_start, clk, rst_n, div_start, !div_stat.busy)
    `RAMR_ASSERT_IMPL(a_div_nonzero, clk, rst_n, div_start, div_b != '0)
    `RAMR_ASSERT_IMPL(a_zero_result, clk, rst_n, out_valid_reg && zero_divisor_reg,
                      res_num_reg == '0 && res_den_reg == '0)

endmodule
